[sv/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam logic [7:0] SLICE_RESET = 8'd10;

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_YIELD  = 3'd1;
  localparam logic [2:0] ACT_EXIT   = 3'd2;
  localparam logic [2:0] ACT_BLOCK  = 3'd3;
  localparam logic [2:0] ACT_WAKEUP = 3'd4;
  localparam logic [2:0] ACT_CREATE = 3'd5;
  localparam logic [2:0] ACT_QUERY  = 3'd6;

  localparam logic [2:0] ST_UNUSED  = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd2;
  localparam logic [2:0] ST_BLOCKED = 3'd3;
  localparam logic [2:0] ST_TERM    = 3'd4;

  localparam logic [1:0] RES_OK       = 2'd0;
  localparam logic [1:0] RES_NO_SLOT  = 2'd1;
  localparam logic [1:0] RES_NO_PID   = 2'd2;

  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_TICK    = 4'd2;
  localparam logic [3:0] OP_MARK    = 4'd3;
  localparam logic [3:0] OP_ADDR0   = 4'd4;
  localparam logic [3:0] OP_REAPCHK = 4'd5;
  localparam logic [3:0] OP_REAP    = 4'd6;
  localparam logic [3:0] OP_CHARGE  = 4'd7;
  localparam logic [3:0] OP_POP     = 4'd8;
  localparam logic [3:0] OP_RUN     = 4'd9;
  localparam logic [3:0] OP_SCAN    = 4'd10;
  localparam logic [3:0] OP_FIN     = 4'd11;
  localparam logic [3:0] OP_OUT     = 4'd12;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       tick_zero;
    logic       cur_term;
    logic       hit;
    logic       last;
    logic       fifo_empty;
    logic       out_busy;
  } stat_t;

endpackage

[sv/rrts_if.sv]
// ----------------------------------------------------------------------------
// rrts_if
// Valid/ready channels of the scheduler: input items, results, config.
// ----------------------------------------------------------------------------
interface rrts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] now_tick;
  logic [15:0] channel;
  logic [31:0] exit_value;
  logic [31:0] query_pid;
  modport source (output valid, action, now_tick, channel, exit_value, query_pid,
                  input ready);
  modport sink (input valid, action, now_tick, channel, exit_value, query_pid,
                output ready);
endinterface

interface rrts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_pid;
  logic [31:0] running_pid;
  logic        switched;
  logic [2:0]  task_status;
  logic [31:0] run_time;
  logic [31:0] exit_status;
  modport source (output valid, status, result_pid, running_pid, switched,
                  task_status, run_time, exit_status, input ready);
  modport sink (input valid, status, result_pid, running_pid, switched,
                task_status, run_time, exit_status, output ready);
endinterface

interface rrts_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] slice_ticks;
  modport source (output valid, slice_ticks, input ready);
  modport sink (input valid, slice_ticks, output ready);
endinterface

[sv/rrts_ctrl.sv]
// ----------------------------------------------------------------------------
// rrts_ctrl
// Sequencer: walks one item through dispatch, slot scans and scheduling.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rrts_pkg::stat_t stat,
  output rrts_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SCHED  = 4'd2;
  localparam logic [3:0] S_REAP   = 4'd3;
  localparam logic [3:0] S_CHARGE = 4'd4;
  localparam logic [3:0] S_WAIT   = 4'd5;
  localparam logic [3:0] S_POP    = 4'd6;
  localparam logic [3:0] S_CHECK  = 4'd7;
  localparam logic [3:0] S_RUN    = 4'd8;
  localparam logic [3:0] S_SCAN   = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op = rrts_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = rrts_pkg::OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.act)
          rrts_pkg::ACT_TICK: begin
            cmd.op = rrts_pkg::OP_TICK;
            state_next = stat.tick_zero ? S_SCHED : S_FIN;
          end
          rrts_pkg::ACT_YIELD: state_next = S_SCHED;
          rrts_pkg::ACT_EXIT, rrts_pkg::ACT_BLOCK: begin
            cmd.op = rrts_pkg::OP_MARK;
            state_next = S_SCHED;
          end
          rrts_pkg::ACT_WAKEUP, rrts_pkg::ACT_CREATE, rrts_pkg::ACT_QUERY: begin
            cmd.op = rrts_pkg::OP_ADDR0;
            state_next = S_SCAN;
          end
          default: state_next = S_FIN;
        endcase
      end
      S_SCHED: begin
        cmd.op = rrts_pkg::OP_REAPCHK;
        state_next = stat.cur_term ? S_CHARGE : S_REAP;
      end
      S_REAP: begin
        cmd.op = rrts_pkg::OP_REAP;
        if (stat.last) state_next = S_CHARGE;
      end
      S_CHARGE: begin
        cmd.op = rrts_pkg::OP_CHARGE;
        state_next = S_WAIT;
      end
      S_WAIT: state_next = S_POP;
      S_POP: begin
        cmd.op = rrts_pkg::OP_POP;
        state_next = stat.fifo_empty ? S_RUN : S_CHECK;
      end
      S_CHECK: state_next = stat.cur_term ? S_POP : S_RUN;
      S_RUN: begin
        cmd.op = rrts_pkg::OP_RUN;
        state_next = S_FIN;
      end
      S_SCAN: begin
        cmd.op = rrts_pkg::OP_SCAN;
        if (stat.last || (stat.hit && stat.act != rrts_pkg::ACT_WAKEUP))
          state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op = rrts_pkg::OP_FIN;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.op = rrts_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

[sv/rrts_dp.sv]
// ----------------------------------------------------------------------------
// rrts_dp
// Datapath: task table, ready FIFO, item and result registers.
// ----------------------------------------------------------------------------
module rrts_dp #(
  parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  rrts_pkg::cmd_t  cmd,
  output rrts_pkg::stat_t stat,
  input  logic [2:0]      action,
  input  logic [31:0]     now_tick,
  input  logic [15:0]     channel,
  input  logic [31:0]     exit_value,
  input  logic [31:0]     query_pid,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_slice,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [1:0]      status,
  output logic [31:0]     result_pid,
  output logic [31:0]     running_pid,
  output logic            switched,
  output logic [2:0]      task_status,
  output logic [31:0]     run_time,
  output logic [31:0]     exit_status
);

  localparam int SW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [SW-1:0] LAST = SW'(TASK_SLOTS - 1);
  localparam logic [CW-1:0] FULL = CW'(TASK_SLOTS);

  logic [2:0]  slot_status [TASK_SLOTS];
  logic [31:0] slot_pid [TASK_SLOTS];
  logic [15:0] slot_channel [TASK_SLOTS];
  logic [31:0] slot_runtime [TASK_SLOTS];
  logic [31:0] slot_last_tick [TASK_SLOTS];
  logic [31:0] slot_exit [TASK_SLOTS];
  logic [7:0]  slot_slice [TASK_SLOTS];
  logic [SW-1:0] ready_fifo [TASK_SLOTS];

  logic [SW-1:0] addr;
  logic [SW-1:0] running;
  logic [SW-1:0] prev_run;
  logic [SW-1:0] head;
  logic [SW-1:0] tail;
  logic [CW-1:0] count;
  logic [SW-1:0] rd;
  logic [31:0]   pid_counter;
  logic [7:0]    slice_ticks;

  logic [2:0]  act;
  logic [31:0] now;
  logic [15:0] chan;
  logic [31:0] xval;
  logic [31:0] qpid;
  logic [1:0]  res_status;
  logic [31:0] res_pid;
  logic [2:0]  res_tstat;
  logic [31:0] res_rt;
  logic [31:0] res_ex;

  logic [2:0]  cur_st;
  logic [7:0]  cur_slice;
  logic [31:0] elapsed;
  logic        hit;
  logic        push;

  assign cur_st = slot_status[addr];
  assign cur_slice = slot_slice[addr];
  assign elapsed = (now == slot_last_tick[addr]) ? 32'd1 : now - slot_last_tick[addr];

  always_comb begin
    unique case (act)
      rrts_pkg::ACT_WAKEUP:
        hit = (cur_st == rrts_pkg::ST_BLOCKED) && (slot_channel[addr] == chan);
      rrts_pkg::ACT_CREATE: hit = (cur_st == rrts_pkg::ST_UNUSED);
      rrts_pkg::ACT_QUERY:
        hit = (cur_st != rrts_pkg::ST_UNUSED) && (slot_pid[addr] == qpid);
      default: hit = 1'b0;
    endcase
  end

  assign push = ((cmd.op == rrts_pkg::OP_CHARGE) && (cur_st == rrts_pkg::ST_RUNNING)) ||
                ((cmd.op == rrts_pkg::OP_SCAN) && hit &&
                 (act == rrts_pkg::ACT_WAKEUP || act == rrts_pkg::ACT_CREATE));

  assign stat.act = act;
  assign stat.tick_zero = (cur_slice <= 8'd1);
  assign stat.cur_term = (cur_st == rrts_pkg::ST_TERM);
  assign stat.hit = hit;
  assign stat.last = (addr == LAST);
  assign stat.fifo_empty = (count == '0);
  assign stat.out_busy = out_valid && !out_ready;

  // slot table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_status[i] <= (i == 0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_UNUSED;
        slot_pid[i] <= '0;
        slot_channel[i] <= '0;
        slot_runtime[i] <= '0;
        slot_last_tick[i] <= '0;
        slot_exit[i] <= '0;
        slot_slice[i] <= '0;
      end
    end else begin
      unique case (cmd.op)
        rrts_pkg::OP_TICK: begin
          if (cur_slice != 8'd0) slot_slice[addr] <= cur_slice - 8'd1;
        end
        rrts_pkg::OP_MARK: begin
          if (act == rrts_pkg::ACT_EXIT) begin
            slot_status[addr] <= rrts_pkg::ST_TERM;
            slot_exit[addr] <= xval;
          end else begin
            slot_status[addr] <= rrts_pkg::ST_BLOCKED;
            slot_channel[addr] <= chan;
          end
        end
        rrts_pkg::OP_REAP: begin
          if (cur_st == rrts_pkg::ST_TERM) slot_status[addr] <= rrts_pkg::ST_UNUSED;
        end
        rrts_pkg::OP_CHARGE: begin
          slot_runtime[addr] <= slot_runtime[addr] + elapsed;
          if (push) begin
            slot_slice[addr] <= slice_ticks;
            slot_status[addr] <= rrts_pkg::ST_READY;
          end
        end
        rrts_pkg::OP_RUN: begin
          slot_status[addr] <= rrts_pkg::ST_RUNNING;
          slot_last_tick[addr] <= now;
        end
        rrts_pkg::OP_SCAN: begin
          if (push) begin
            slot_status[addr] <= rrts_pkg::ST_READY;
            slot_channel[addr] <= '0;
            if (act == rrts_pkg::ACT_CREATE) begin
              slot_pid[addr] <= pid_counter;
              slot_runtime[addr] <= '0;
              slot_last_tick[addr] <= '0;
              slot_exit[addr] <= '0;
              slot_slice[addr] <= slice_ticks;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ready FIFO storage
  always_ff @(posedge clk) begin
    if (push && count != FULL) ready_fifo[tail] <= addr;
    rd <= ready_fifo[head];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      running <= '0;
      prev_run <= '0;
      head <= '0;
      tail <= '0;
      count <= '0;
      pid_counter <= 32'd1;
      slice_ticks <= rrts_pkg::SLICE_RESET;
      act <= rrts_pkg::ACT_TICK;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) slice_ticks <= cfg_slice;
      if (push && count != FULL) begin
        tail <= (tail == LAST) ? '0 : tail + SW'(1);
        count <= count + CW'(1);
      end
      if (cmd.op == rrts_pkg::OP_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (cmd.op)
        rrts_pkg::OP_LOAD: begin
          act <= action;
          addr <= running;
          prev_run <= running;
        end
        rrts_pkg::OP_ADDR0: addr <= '0;
        rrts_pkg::OP_REAPCHK: begin
          if (cur_st != rrts_pkg::ST_TERM) addr <= '0;
        end
        rrts_pkg::OP_REAP: begin
          addr <= (addr == LAST) ? running : addr + SW'(1);
        end
        rrts_pkg::OP_POP: begin
          if (count == '0) addr <= '0;
          else begin
            addr <= rd;
            head <= (head == LAST) ? '0 : head + SW'(1);
            count <= count - CW'(1);
          end
        end
        rrts_pkg::OP_RUN: running <= addr;
        rrts_pkg::OP_SCAN: begin
          if (addr != LAST) addr <= addr + SW'(1);
          if (hit && act == rrts_pkg::ACT_CREATE) pid_counter <= pid_counter + 32'd1;
        end
        rrts_pkg::OP_FIN: addr <= running;
        default: ;
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (cmd.op == rrts_pkg::OP_LOAD) begin
      now <= now_tick;
      chan <= channel;
      xval <= exit_value;
      qpid <= query_pid;
      res_pid <= '0;
      res_tstat <= '0;
      res_rt <= '0;
      res_ex <= '0;
      res_status <= (action == rrts_pkg::ACT_CREATE) ? rrts_pkg::RES_NO_SLOT :
                    (action == rrts_pkg::ACT_QUERY) ? rrts_pkg::RES_NO_PID :
                    rrts_pkg::RES_OK;
    end
    if (cmd.op == rrts_pkg::OP_SCAN && hit) begin
      if (act == rrts_pkg::ACT_CREATE) begin
        res_status <= rrts_pkg::RES_OK;
        res_pid <= pid_counter;
      end else if (act == rrts_pkg::ACT_QUERY) begin
        res_status <= rrts_pkg::RES_OK;
        res_pid <= qpid;
        res_tstat <= cur_st;
        res_rt <= slot_runtime[addr];
        res_ex <= slot_exit[addr];
      end
    end
    if (cmd.op == rrts_pkg::OP_OUT) begin
      status <= res_status;
      result_pid <= res_pid;
      running_pid <= slot_pid[addr];
      switched <= (running != prev_run);
      task_status <= res_tstat;
      run_time <= res_rt;
      exit_status <= res_ex;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("ready FIFO count out of range");
  a_run_state: assert property (@(posedge clk) disable iff (rst)
    cmd.op == rrts_pkg::OP_RUN |=> slot_status[running] == rrts_pkg::ST_RUNNING)
    else $error("dispatched slot not running");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> head == tail)
    else $error("empty FIFO with unequal pointers");

endmodule

[sv/round_robin_task_scheduler_top.sv]
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_top
// Round-robin time-slice scheduler over a fixed task table.
// ----------------------------------------------------------------------------
// Channels: in_ch carries one scheduler event per beat (tick, yield, exit,
// block, wakeup, create, query) with the timer value; out_ch returns exactly
// one result beat per event; cfg writes the slice length in ticks.
// The sequencer walks the slot table one slot a cycle: a tick with time left
// or an undefined event goes straight to the result; wakeup, create and query
// scan the slots (create and query stop at the first hit); scheduling runs a
// reap scan and then pops the FIFO until it finds a live task or runs empty;
// an exit skips the reap scan.
// One event is in flight at a time; the next is taken as soon as
// the result sits in the output register.
// Reset (synchronous, rst high) leaves the idle task in slot 0 running, all
// other slots unused, the FIFO empty, next pid 1, slice 10.
// A stalled receiver holds the result; the block then finishes at most one
// more event and waits with it until the output register frees.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_top #(
  parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
  input logic       clk,
  input logic       rst,
  rrts_in_if.sink   in_ch,
  rrts_out_if.source out_ch,
  rrts_cfg_if.sink  cfg
);

  rrts_pkg::cmd_t  cmd;
  rrts_pkg::stat_t stat;

  assign cfg.ready = 1'b1;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrts_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .action      (in_ch.action),
    .now_tick    (in_ch.now_tick),
    .channel     (in_ch.channel),
    .exit_value  (in_ch.exit_value),
    .query_pid   (in_ch.query_pid),
    .cfg_we      (cfg.valid),
    .cfg_slice   (cfg.slice_ticks),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .status      (out_ch.status),
    .result_pid  (out_ch.result_pid),
    .running_pid (out_ch.running_pid),
    .switched    (out_ch.switched),
    .task_status (out_ch.task_status),
    .run_time    (out_ch.run_time),
    .exit_status (out_ch.exit_status)
  );

endmodule
